// File: hdl/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg: shared types and constants of the timed maneuver sequencer
// Holds the maneuver codes, register indexes, the payload and state structs
// and the line-sensor decode function.
// ----------------------------------------------------------------------------
package tms_pkg;

    // Maneuver codes as they appear on the active_maneuver output.
    typedef enum logic [2:0] {
        MAN_IDLE   = 3'd0,
        MAN_FWD    = 3'd1,
        MAN_REV    = 3'd2,
        MAN_LEFT   = 3'd3,
        MAN_RIGHT  = 3'd4,
        MAN_LFWD   = 3'd5,
        MAN_RFWD   = 3'd6,
        MAN_SEARCH = 3'd7
    } t_maneuver;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_TIME   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SPEED = 1'b1;

    // Reset values of the registers.
    localparam logic [15:0] MOVE_TIME_RST   = 16'd200;
    localparam logic [7:0]  DRIVE_SPEED_RST = 8'd110;

    // Duty reduction used when an obstacle is seen in front during search.
    localparam logic [7:0] SLOW_DELTA = 8'd20;

    // Obstacle codes.
    localparam logic [1:0] OBS_NONE  = 2'd0;
    localparam logic [1:0] OBS_FRONT = 2'd1;

    // One control pass as it arrives on the input channel.
    typedef struct packed {
        logic [3:0]  sensor_pattern;
        logic [1:0]  obstacle_code;
        logic [31:0] now_ms;
    } t_item;

    // Configuration register contents.
    typedef struct packed {
        logic [15:0] move_time_ms;
        logic [7:0]  drive_speed;
    } t_cfg;

    // Sequencer state carried from one pass to the next.
    typedef struct packed {
        t_maneuver   maneuver;
        logic [31:0] start_stamp;
        logic        dir_a;
        logic        dir_b;
        logic [7:0]  duty;
    } t_state;

    // Decode the four line-sensor bits to the requested maneuver.
    function automatic t_maneuver decode_pattern(input logic [3:0] pat);
        t_maneuver m;
        case (pat) inside
            4'b1100, 4'b1101, 4'b1110:          m = MAN_FWD;
            4'b0011, 4'b0111, 4'b1011:          m = MAN_REV;
            4'b0000, 4'b1010:                   m = MAN_LEFT;
            4'b0101, 4'b0110, 4'b1001:          m = MAN_RIGHT;
            4'b0010, 4'b1000:                   m = MAN_LFWD;
            4'b0001, 4'b0100:                   m = MAN_RFWD;
            4'b1111:                            m = MAN_SEARCH;
            default:                            m = MAN_IDLE;
        endcase
        return m;
    endfunction

endpackage

// File: hdl/tms_if.sv
// ----------------------------------------------------------------------------
// tms_if: channel interfaces of the timed maneuver sequencer
// Valid/ready channels for control passes, results and register writes.
// ----------------------------------------------------------------------------

// Input channel: one control pass per transfer.
interface tms_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  sensor_pattern;
    logic [1:0]  obstacle_code;
    logic [31:0] now_ms;

    modport source (output valid, output sensor_pattern, output obstacle_code,
                    output now_ms, input ready);
    modport sink   (input valid, input sensor_pattern, input obstacle_code,
                    input now_ms, output ready);
endinterface

// Output channel: one result per transfer.
interface tms_out_if;
    logic       valid;
    logic       ready;
    logic       dir_left_motor;
    logic       dir_right_motor;
    logic [7:0] pwm_duty;
    logic [2:0] active_maneuver;

    modport source (output valid, output dir_left_motor, output dir_right_motor,
                    output pwm_duty, output active_maneuver, input ready);
    modport sink   (input valid, input dir_left_motor, input dir_right_motor,
                    input pwm_duty, input active_maneuver, output ready);
endinterface

// Configuration write channel: register index and write data.
interface tms_cfg_if import tms_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/tms_cfg_regs.sv
// ----------------------------------------------------------------------------
// tms_cfg_regs: configuration registers
// Holds the phase length and drive speed, written through the config channel.
// ----------------------------------------------------------------------------
module tms_cfg_regs import tms_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tms_cfg_if.sink i_cfg,
    output t_cfg   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;

    // Decode the register index of a write transfer.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MOVE_TIME:   n_cfg.move_time_ms = i_cfg.data;
                CFG_DRIVE_SPEED: n_cfg.drive_speed  = i_cfg.data[7:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_time_ms <= MOVE_TIME_RST;
            r_cfg.drive_speed  <= DRIVE_SPEED_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/tms_step.sv
// ----------------------------------------------------------------------------
// tms_step: single control pass logic
// Decodes the sensor pattern, latches a new maneuver and its start time, and
// works out the motor writes for the elapsed time of the active maneuver.
// ----------------------------------------------------------------------------
module tms_step import tms_pkg::*; (
    input  t_item  i_item,
    input  t_cfg   i_cfg,
    input  t_state i_state,
    output t_state o_state
);

    t_maneuver   want;
    logic        obs_block;
    t_maneuver   man_lat;
    logic [31:0] stamp_lat;
    logic [31:0] elapsed;
    logic [16:0] t2;
    logic        in_first;
    logic        in_second;

    // Search is held off by any obstacle code other than none.
    assign want      = decode_pattern(i_item.sensor_pattern);
    assign obs_block = (want == MAN_SEARCH) && (i_item.obstacle_code != OBS_NONE);

    // A maneuver that is already active keeps its start stamp.
    always_comb begin
        man_lat   = i_state.maneuver;
        stamp_lat = i_state.start_stamp;
        if (!obs_block && (i_state.maneuver != want)) begin
            man_lat   = want;
            stamp_lat = i_item.now_ms;
        end
    end

    // Phase windows measured from the start stamp, modulo 2^32.
    assign elapsed   = i_item.now_ms - stamp_lat;
    assign t2        = {1'b0, i_cfg.move_time_ms} + {1'b0, i_cfg.move_time_ms};
    assign in_first  = elapsed <= {16'd0, i_cfg.move_time_ms};
    assign in_second = elapsed <= {15'd0, t2};

    // Motor writes; a later write in the same pass wins.
    always_comb begin
        o_state             = i_state;
        o_state.maneuver    = man_lat;
        o_state.start_stamp = stamp_lat;

        if (obs_block && (i_item.obstacle_code == OBS_FRONT)) begin
            o_state.dir_a = 1'b0;
            o_state.dir_b = 1'b0;
            o_state.duty  = i_cfg.drive_speed - SLOW_DELTA;
        end

        case (man_lat)
            MAN_FWD, MAN_REV, MAN_LEFT, MAN_RIGHT: begin
                if (in_first) begin
                    o_state.dir_a = (man_lat == MAN_REV) || (man_lat == MAN_LEFT);
                    o_state.dir_b = (man_lat == MAN_REV) || (man_lat == MAN_RIGHT);
                    o_state.duty  = i_cfg.drive_speed;
                end else begin
                    o_state.maneuver = MAN_IDLE;
                end
            end
            MAN_LFWD, MAN_RFWD, MAN_SEARCH: begin
                if (in_first) begin
                    o_state.dir_a = (man_lat == MAN_LFWD);
                    o_state.dir_b = (man_lat != MAN_LFWD);
                    o_state.duty  = i_cfg.drive_speed;
                end else if (in_second) begin
                    o_state.dir_a = 1'b0;
                    o_state.dir_b = 1'b0;
                    o_state.duty  = i_cfg.drive_speed;
                end else begin
                    o_state.maneuver = MAN_IDLE;
                end
            end
            default: begin
                o_state.maneuver = man_lat;
            end
        endcase
    end

endmodule

// File: hdl/timed_maneuver_sequencer_unit.sv
// ----------------------------------------------------------------------------
// timed_maneuver_sequencer_unit: top level of the timed maneuver sequencer
// Input register, single-pass step logic with state, and result register.
// ----------------------------------------------------------------------------
// Each control pass transferred in gives exactly one result. A pass is taken
// into an input register, evaluated against the sequencer state by the
// combinational step logic, and the result lands in the result register,
// from which it leaves on the output handshake. One pass per cycle is
// sustained while the output is ready. The input register moves forward
// whenever the result register is empty or being emptied, so a new pass is
// taken while a result is still waiting. Register writes on the
// configuration channel are always taken and should only be issued while no
// pass is in flight.
module timed_maneuver_sequencer_unit import tms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tms_in_if.sink    i_item,
    tms_out_if.source o_result,
    tms_cfg_if.sink   i_cfg
);

    t_cfg   cfg;
    t_item  r_in;
    logic   r_in_valid;
    t_state r_state;
    t_state n_state;
    t_state r_out;
    logic   r_out_valid;
    logic   in_fire;
    logic   step_fire;

    // Configuration registers.
    tms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Handshake: the input stage advances when the result stage can load.
    assign step_fire    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || step_fire;
    assign in_fire      = i_item.valid && i_item.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (step_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.sensor_pattern <= i_item.sensor_pattern;
            r_in.obstacle_code  <= i_item.obstacle_code;
            r_in.now_ms         <= i_item.now_ms;
        end
    end

    // Step logic for the pass in the input register.
    tms_step u_step (
        .i_item  (r_in),
        .i_cfg   (cfg),
        .i_state (r_state),
        .o_state (n_state)
    );

    // Sequencer state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.maneuver    <= MAN_IDLE;
            r_state.start_stamp <= 32'd0;
            r_state.dir_a       <= 1'b0;
            r_state.dir_b       <= 1'b0;
            r_state.duty        <= 8'd0;
            r_out_valid         <= 1'b0;
        end else if (step_fire) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out <= n_state;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.dir_left_motor  = r_out.dir_a;
    assign o_result.dir_right_motor = r_out.dir_b;
    assign o_result.pwm_duty        = r_out.duty;
    assign o_result.active_maneuver = r_out.maneuver;

`ifndef SYNTH
    // A pending result always matches the current sequencer state.
    a_out_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.maneuver == r_state.maneuver)
                        && (r_out.duty == r_state.duty))
        else $error("result register out of step with sequencer state");

    // A pass waiting in the input register is never dropped.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step_fire) |=> r_in_valid)
        else $error("input register lost a pass");

    // An active maneuver always drives the configured speed.
    a_active_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.maneuver != MAN_IDLE)) |-> (r_out.duty == cfg.drive_speed))
        else $error("active maneuver with wrong duty");

    // Reset empties both register stages.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_valid && !r_out_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

// File: tb/sv/tb_timed_maneuver_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tb_timed_maneuver_sequencer_unit: self-checking bench of the sequencer
// A queue-fed driver sends control passes and a clocked monitor checks every
// result against a cycle-free predictor of the maneuver timing. Register
// settings and handshake idling are varied across several phases.
// ----------------------------------------------------------------------------
module tb_timed_maneuver_sequencer_unit;
    import tms_pkg::*;

    // Watchdog limit in cycles without any transfer.
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned MAX_REPORTS    = 10;

    // One result as seen on the output channel.
    typedef struct packed {
        logic       dir_a;
        logic       dir_b;
        logic [7:0] duty;
        t_maneuver  man;
    } t_motor_out;

    logic i_clk;
    logic i_rst_n;

    tms_in_if  item_if ();
    tms_out_if res_if ();
    tms_cfg_if cfg_if ();

    timed_maneuver_sequencer_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    // Stimulus and bookkeeping shared between the processes.
    t_item       sensor_pass_q[$];
    t_motor_out  pending_motor_q[$];
    int unsigned queued_total;
    int unsigned accepted_total;
    int unsigned checked_total;
    int unsigned fail_count;
    int unsigned cfg_writes;
    int unsigned latch_count;
    int unsigned timeout_count;
    int unsigned slowdown_count;
    int unsigned idle_cycles;
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    bit          hold_sender;
    bit          pass_taken;

    // Predictor copy of the registers and the sequencer state.
    logic [15:0] phase_ms;
    logic [7:0]  speed;
    t_maneuver   cur_man;
    logic [31:0] stamp;
    logic        dir_a;
    logic        dir_b;
    logic [7:0]  duty;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Work out the motor outputs after one control pass and advance the state.
    function automatic t_motor_out advance_sequencer(input t_item p);
        t_maneuver   want;
        logic [31:0] elapsed;
        logic [16:0] two_phase;
        case (p.sensor_pattern)
            4'h0, 4'hA:       want = MAN_LEFT;
            4'h1, 4'h4:       want = MAN_RFWD;
            4'h2, 4'h8:       want = MAN_LFWD;
            4'h3, 4'h7, 4'hB: want = MAN_REV;
            4'h5, 4'h6, 4'h9: want = MAN_RIGHT;
            4'hC, 4'hD, 4'hE: want = MAN_FWD;
            default:          want = MAN_SEARCH;
        endcase
        two_phase = {1'b0, phase_ms} + {1'b0, phase_ms};

        // An obstacle blocks search from starting; a front one slows us down.
        if (want == MAN_SEARCH && p.obstacle_code != OBS_NONE) begin
            if (p.obstacle_code == OBS_FRONT) begin
                dir_a = 1'b0;
                dir_b = 1'b0;
                duty  = speed - SLOW_DELTA;
                slowdown_count++;
            end
        end else if (cur_man != want) begin
            cur_man = want;
            stamp   = p.now_ms;
            latch_count++;
        end

        // The active maneuver writes last, so its outputs win.
        elapsed = p.now_ms - stamp;
        case (cur_man)
            MAN_FWD, MAN_REV, MAN_LEFT, MAN_RIGHT: begin
                if (elapsed <= {16'd0, phase_ms}) begin
                    dir_a = (cur_man == MAN_REV) || (cur_man == MAN_LEFT);
                    dir_b = (cur_man == MAN_REV) || (cur_man == MAN_RIGHT);
                    duty  = speed;
                end else begin
                    cur_man = MAN_IDLE;
                    timeout_count++;
                end
            end
            MAN_LFWD, MAN_RFWD, MAN_SEARCH: begin
                if (elapsed <= {16'd0, phase_ms}) begin
                    dir_a = (cur_man == MAN_LFWD);
                    dir_b = (cur_man != MAN_LFWD);
                    duty  = speed;
                end else if (elapsed <= {15'd0, two_phase}) begin
                    dir_a = 1'b0;
                    dir_b = 1'b0;
                    duty  = speed;
                end else begin
                    cur_man = MAN_IDLE;
                    timeout_count++;
                end
            end
            default: ;
        endcase
        return '{dir_a: dir_a, dir_b: dir_b, duty: duty, man: cur_man};
    endfunction

    // Driver: presents queued passes and randomizes the result ready.
    always @(negedge i_clk) begin
        t_item next_pass;
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else if (pass_taken || !item_if.valid) begin
            if (sensor_pass_q.size() != 0 && !hold_sender &&
                $urandom_range(0, 99) >= src_idle_pct) begin
                next_pass = sensor_pass_q.pop_front();
                item_if.valid          <= 1'b1;
                item_if.sensor_pattern <= next_pass.sensor_pattern;
                item_if.obstacle_code  <= next_pass.obstacle_code;
                item_if.now_ms         <= next_pass.now_ms;
            end else begin
                item_if.valid <= 1'b0;
            end
        end
        res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Monitor: tracks register writes, checks results and predicts new ones.
    always @(posedge i_clk) begin
        t_motor_out seen;
        t_motor_out want;
        bit         quiet;
        if (!i_rst_n) begin
            pass_taken = 1'b0;
            phase_ms   = MOVE_TIME_RST;
            speed      = DRIVE_SPEED_RST;
            cur_man    = MAN_IDLE;
            stamp      = '0;
            dir_a      = 1'b0;
            dir_b      = 1'b0;
            duty       = '0;
        end else begin
            quiet = 1'b1;

            // Register write transfer.
            if (cfg_if.valid && cfg_if.ready) begin
                quiet = 1'b0;
                cfg_writes++;
                if (cfg_if.index == CFG_MOVE_TIME) begin
                    phase_ms = cfg_if.data;
                end else if (cfg_if.index == CFG_DRIVE_SPEED) begin
                    speed = cfg_if.data[7:0];
                end
            end

            // Result transfer against the oldest expectation.
            if (res_if.valid && res_if.ready) begin
                quiet = 1'b0;
                seen = '{dir_a: res_if.dir_left_motor, dir_b: res_if.dir_right_motor,
                         duty: res_if.pwm_duty, man: t_maneuver'(res_if.active_maneuver)};
                if (pending_motor_q.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("Unexpected result: dirA=%0b dirB=%0b duty=%0d man=%0d",
                                 seen.dir_a, seen.dir_b, seen.duty, seen.man);
                    end
                    fail_count++;
                end else begin
                    want = pending_motor_q.pop_front();
                    if (seen !== want) begin
                        if (fail_count < MAX_REPORTS) begin
                            $display({"Mismatch on result %0d: expected dirA=%0b dirB=%0b ",
                                      "duty=%0d man=%0d, got dirA=%0b dirB=%0b duty=%0d man=%0d"},
                                     checked_total, want.dir_a, want.dir_b, want.duty,
                                     want.man, seen.dir_a, seen.dir_b, seen.duty, seen.man);
                        end
                        fail_count++;
                    end
                end
                checked_total++;
            end

            // Input transfer: predict its result.
            pass_taken = item_if.valid && item_if.ready;
            if (pass_taken) begin
                quiet = 1'b0;
                pending_motor_q.push_back(advance_sequencer('{
                    sensor_pattern: item_if.sensor_pattern,
                    obstacle_code:  item_if.obstacle_code,
                    now_ms:         item_if.now_ms}));
                accepted_total++;
            end

            // Watchdog on cycles without any transfer.
            if (quiet) begin
                idle_cycles++;
            end else begin
                idle_cycles = 0;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired after %0d idle cycles", idle_cycles);
                $display("[timed_maneuver_sequencer_unit] ERROR");
                $finish;
            end
        end
    end

    // Add one control pass to the driver queue.
    task automatic queue_pass(input logic [3:0] pat, input logic [1:0] obs,
                              input logic [31:0] now);
        sensor_pass_q.push_back('{sensor_pattern: pat, obstacle_code: obs, now_ms: now});
        queued_total++;
    endtask

    // Wait until every queued pass has produced its checked result.
    task automatic wait_until_drained();
        do @(negedge i_clk); while (checked_total != queued_total);
    endtask

    // One register write transfer.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Runs of passes with advancing time so maneuvers go through their phases.
    task automatic queue_random_passes(input int unsigned count, input int unsigned mt);
        int unsigned  made;
        int unsigned  run_len;
        int unsigned  roll;
        logic [3:0]   pat;
        logic [1:0]   obs;
        logic [31:0]  base;
        logic [31:0]  off;
        made = 0;
        while (made < count) begin
            run_len = $urandom_range(1, 8);
            pat     = 4'($urandom_range(0, 15));
            off     = '0;
            if ($urandom_range(0, 3) == 0) begin
                base = 32'hFFFF_FFFF - $urandom_range(0, 2 * mt + 8);
            end else begin
                base = $urandom();
            end
            for (int k = 0; k < run_len && made < count; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    // Noise: any pattern, any obstacle code, any time.
                    queue_pass(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                               $urandom());
                end else begin
                    if (roll < 25) begin
                        pat = 4'($urandom_range(0, 15));
                    end
                    // Land on the phase boundaries now and then.
                    if (roll < 40 && k > 0) begin
                        case ($urandom_range(0, 3))
                            0:       off = mt;
                            1:       off = mt + 1;
                            2:       off = 2 * mt;
                            default: off = 2 * mt + 1;
                        endcase
                    end else begin
                        off = off + $urandom_range(0, mt / 3 + 1);
                    end
                    if (pat == 4'hF && $urandom_range(0, 2) == 0) begin
                        obs = 2'($urandom_range(1, 3));
                    end else if ($urandom_range(0, 9) == 0) begin
                        obs = 2'($urandom_range(0, 3));
                    end else begin
                        obs = OBS_NONE;
                    end
                    queue_pass(pat, obs, base + off);
                end
                made++;
            end
        end
    endtask

    // Stimulus sequence: reset, directed passes, then random phases.
    initial begin
        int unsigned mt;
        logic [7:0]  sp;
        int unsigned phase_start;
        i_rst_n                = 1'b0;
        item_if.valid          = 1'b0;
        item_if.sensor_pattern = '0;
        item_if.obstacle_code  = '0;
        item_if.now_ms         = '0;
        res_if.ready           = 1'b0;
        cfg_if.valid           = 1'b0;
        cfg_if.index           = '0;
        cfg_if.data            = '0;
        src_idle_pct           = 0;
        snk_stall_pct          = 0;
        hold_sender            = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Search through both phases, with obstacles blocking and slowing it.
        queue_pass(4'hF, OBS_NONE, 32'd0);
        queue_pass(4'hF, OBS_FRONT, 32'd200);
        queue_pass(4'hF, 2'd2, 32'd201);
        queue_pass(4'hF, 2'd3, 32'd400);
        queue_pass(4'hF, OBS_FRONT, 32'd401);
        // Every sensor pattern once.
        for (int p = 0; p < 16; p++) begin
            queue_pass(p[3:0], OBS_NONE, 32'd1000 + 32'd300 * p);
        end
        // Time wrapping through zero, the single-phase boundary, time going back.
        queue_pass(4'h3, OBS_NONE, 32'hFFFF_FF9C);
        queue_pass(4'h7, OBS_NONE, 32'h0000_0064);
        queue_pass(4'hB, OBS_NONE, 32'h0000_0065);
        queue_pass(4'h3, OBS_NONE, 32'hFFFF_FFFF);
        queue_pass(4'h7, OBS_NONE, 32'hFFFF_FFF0);
        wait_until_drained();

        // Random phases, each with its own register setting and idling mode.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    mt = 0;
                    sp = 8'd0;
                end
                1: begin
                    mt = 65535;
                    sp = 8'd255;
                end
                2: begin
                    mt = $urandom_range(1, 40);
                    sp = 8'd20;
                end
                3: begin
                    mt = $urandom_range(0, 65535);
                    sp = 8'($urandom_range(0, 19));
                end
                default: begin
                    mt = $urandom_range(2, 8);
                    sp = 8'($urandom_range(0, 255));
                end
            endcase
            write_register(CFG_MOVE_TIME, mt[15:0]);
            write_register(CFG_DRIVE_SPEED, {8'h00, sp});
            case (ph % 4)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 70;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 70;
                end
                default: begin
                    src_idle_pct  = 10;
                    snk_stall_pct = 10;
                end
            endcase
            phase_start = queued_total;
            queue_random_passes(90, mt);

            // Midway the sender holds off until every result is back.
            while (accepted_total < phase_start + 45) @(negedge i_clk);
            @(posedge i_clk);
            hold_sender = 1'b1;
            do @(negedge i_clk); while (accepted_total != checked_total || item_if.valid);
            hold_sender = 1'b0;
            wait_until_drained();
        end

        // Let any stray result show up before closing.
        repeat (8) @(negedge i_clk);
        if (pending_motor_q.size() != 0) begin
            $display("%0d expected results never arrived", pending_motor_q.size());
            fail_count += pending_motor_q.size();
        end
        $display("Checked %0d passes across %0d register writes and four handshake modes.",
                 checked_total, cfg_writes);
        $display("Saw %0d maneuver starts, %0d time-outs to idle, %0d front-obstacle slowdowns.",
                 latch_count, timeout_count, slowdown_count);
        if (fail_count == 0) begin
            $display("[timed_maneuver_sequencer_unit] OK");
        end else begin
            $display("[timed_maneuver_sequencer_unit] ERROR");
        end
        $finish;
    end

endmodule
